[rtl/jbq_pkg.sv]
// Shared constants, tables and codes for the JPEG block quantizer.
`timescale 1ns / 1ps

package jbq_pkg;

    // Block geometry and field widths
    localparam int BLOCK_DIM = 8;
    localparam int POS_W     = $clog2(BLOCK_DIM);
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 32;
    localparam int QUAL_W    = 7;
    localparam int CFG_W     = QUAL_W;

    // Internal datapath widths
    localparam int MAG_W     = COEF_W;          // magnitude of a coefficient, up to 2^15
    localparam int BASE_W    = 8;
    localparam int SCALE_W   = 14;              // up to 10000
    localparam int PROD_W    = 21;              // base * scale, up to 1500000
    localparam int PRE_W     = 6;               // times 64 before the divide by 25
    localparam int RECIP_W   = 28;
    localparam int RECIP_SHIFT = 32;
    localparam int WIDE_W    = PROD_W + PRE_W + RECIP_W;
    localparam int STEP_W    = 23;              // Q8 step, up to 5760000
    localparam int NUM_W     = 23;              // 32 * |c| + step
    localparam int DEN_W     = STEP_W + 1;      // 2 * step
    localparam int QUO_W     = 12;              // quantized level magnitude, up to 2048
    localparam int MUL_W     = MAG_W + STEP_W;  // |c| * step
    localparam int DIV_STAGES = QUO_W;

    // Reciprocal of 25, exact for every product below 2^27
    localparam logic [RECIP_W-1:0] RECIP_25 = 28'd171798692;

    // Quality handling
    localparam logic [QUAL_W-1:0] QUAL_RESET = 7'd50;
    localparam logic [QUAL_W-1:0] QUAL_MIN   = 7'd1;
    localparam logic [QUAL_W-1:0] QUAL_MAX   = 7'd100;
    localparam logic [QUAL_W-1:0] QUAL_KNEE  = 7'd50;
    localparam logic [QUAL_W:0]   SCALE_TOP  = 8'd200;

    // One in Q8
    localparam logic [STEP_W-1:0] STEP_ONE = 23'd256;

    // Register indexes
    typedef enum logic [0:0] {
        REG_QUALITY   = 1'b0,
        REG_DIRECTION = 1'b1
    } t_reg_idx;

    // Direction codes
    typedef enum logic {
        DIR_QUANT   = 1'b0,
        DIR_DEQUANT = 1'b1
    } t_dir;

    // Base table, indexed by {row, col}
    localparam logic [BASE_W-1:0] BASE_TABLE [BLOCK_DIM*BLOCK_DIM] = '{
        8'd32,  8'd33,  8'd34,  8'd37,  8'd50,  8'd60,  8'd70,  8'd80,
        8'd33,  8'd35,  8'd36,  8'd44,  8'd53,  8'd75,  8'd85,  8'd90,
        8'd34,  8'd36,  8'd40,  8'd45,  8'd55,  8'd78,  8'd90,  8'd95,
        8'd37,  8'd44,  8'd45,  8'd50,  8'd65,  8'd95,  8'd97,  8'd98,
        8'd50,  8'd53,  8'd55,  8'd65,  8'd80,  8'd100, 8'd110, 8'd115,
        8'd60,  8'd75,  8'd78,  8'd95,  8'd100, 8'd120, 8'd125, 8'd130,
        8'd70,  8'd85,  8'd90,  8'd97,  8'd110, 8'd125, 8'd140, 8'd145,
        8'd80,  8'd90,  8'd95,  8'd98,  8'd115, 8'd130, 8'd145, 8'd150
    };

    // 10000 / quality for quality below the knee; entry zero is never read
    localparam int SCALE_ENTRIES = 50;
    localparam logic [SCALE_W-1:0] SCALE_TABLE [SCALE_ENTRIES] = '{
        14'd10000, 14'd10000, 14'd5000, 14'd3333, 14'd2500,
        14'd2000,  14'd1666,  14'd1428, 14'd1250, 14'd1111,
        14'd1000,  14'd909,   14'd833,  14'd769,  14'd714,
        14'd666,   14'd625,   14'd588,  14'd555,  14'd526,
        14'd500,   14'd476,   14'd454,  14'd434,  14'd416,
        14'd400,   14'd384,   14'd370,  14'd357,  14'd344,
        14'd333,   14'd322,   14'd312,  14'd303,  14'd294,
        14'd285,   14'd277,   14'd270,  14'd263,  14'd256,
        14'd250,   14'd243,   14'd238,  14'd232,  14'd227,
        14'd222,   14'd217,   14'd212,  14'd208,  14'd204
    };

endpackage

[rtl/jpeg_block_quantizer.sv]
// Top level of the JPEG block quantizer: quality-scaled step and pipelined divide/multiply.
`timescale 1ns / 1ps

// Usage
// - Input channel: i_valid / o_stall with i_coef_row, i_coef_col, i_coef_value. An item is
//   taken at a rising edge where i_valid is high and o_stall is low.
// - Output channel: o_valid / i_stall with o_out_value, one result per item, in order.
// - Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; quality (index 0) and direction
//   (index 1). Write only while no item is in flight.
// - Throughput: one item per cycle while o_stall is low. The step is built in four stages (table lookups,
//   base times scale, reciprocal multiply by 1/25, floor and quadrant factor), a fifth
//   stage forms the divide operands and the dequantize product, and the divide is a
//   restoring divider with one quotient bit per stage, twelve stages.
// - Path: an accepted item passes stages 1 to 5, the divider stages and the output register before o_valid rises.
// - Stall: each stage only holds when it is full and the stage after it holds, so
//   empty slots fill up and items keep being taken while a result waits at the output.
//   o_stall rises only when every stage is full and i_stall is high.
// - Reset: synchronous, active low. It empties the pipeline and sets quality to 50 and
//   direction to quantize.
module jpeg_block_quantizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [jbq_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [jbq_pkg::POS_W-1:0]      i_coef_row,
    input  logic [jbq_pkg::POS_W-1:0]      i_coef_col,
    input  logic signed [jbq_pkg::COEF_W-1:0] i_coef_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [jbq_pkg::OUT_W-1:0] o_out_value
);

    localparam int POS_W    = jbq_pkg::POS_W;
    localparam int QUAL_W   = jbq_pkg::QUAL_W;
    localparam int MAG_W    = jbq_pkg::MAG_W;
    localparam int BASE_W   = jbq_pkg::BASE_W;
    localparam int SCALE_W  = jbq_pkg::SCALE_W;
    localparam int PROD_W   = jbq_pkg::PROD_W;
    localparam int PRE_W    = jbq_pkg::PRE_W;
    localparam int WIDE_W   = jbq_pkg::WIDE_W;
    localparam int STEP_W   = jbq_pkg::STEP_W;
    localparam int NUM_W    = jbq_pkg::NUM_W;
    localparam int DEN_W    = jbq_pkg::DEN_W;
    localparam int QUO_W    = jbq_pkg::QUO_W;
    localparam int MUL_W    = jbq_pkg::MUL_W;
    localparam int OUT_W    = jbq_pkg::OUT_W;
    localparam int NDIV     = jbq_pkg::DIV_STAGES;
    localparam int RR_W     = MUL_W + 1 - 4;
    localparam int TRIAL_W  = DEN_W + QUO_W;

    // Configuration registers
    logic [QUAL_W-1:0]   r_quality;
    logic                r_direction;

    // Stage 1: lookups
    logic                r1_valid, r1_dir, r1_neg, r1_quad;
    logic [MAG_W-1:0]    r1_mag;
    logic [BASE_W-1:0]   r1_base;
    logic [SCALE_W-1:0]  r1_scale;
    // Stage 2: base times scale
    logic                r2_valid, r2_dir, r2_neg, r2_quad;
    logic [MAG_W-1:0]    r2_mag;
    logic [PROD_W-1:0]   r2_prod;
    // Stage 3: reciprocal product
    logic                r3_valid, r3_dir, r3_neg, r3_quad;
    logic [MAG_W-1:0]    r3_mag;
    logic [WIDE_W-1:0]   r3_wide;
    // Stage 4: final step
    logic                r4_valid, r4_dir, r4_neg;
    logic [MAG_W-1:0]    r4_mag;
    logic [STEP_W-1:0]   r4_step;
    // Stage 5: divide operands and dequantize product
    logic                r5_valid, r5_dir, r5_neg;
    logic [NUM_W-1:0]    r5_num;
    logic [DEN_W-1:0]    r5_den;
    logic [MUL_W-1:0]    r5_mul;
    // Divider stages
    logic                r_dv   [NDIV];
    logic                r_ddir [NDIV];
    logic                r_dneg [NDIV];
    logic [NUM_W-1:0]    r_drem [NDIV];
    logic [DEN_W-1:0]    r_dden [NDIV];
    logic [QUO_W-1:0]    r_dquo [NDIV];
    logic [OUT_W-1:0]    r_dres [NDIV];
    // Output register
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_value;

    // Next values
    logic [QUAL_W-1:0]   w_q;
    logic                n1_neg, n1_quad;
    logic [MAG_W-1:0]    n1_mag;
    logic [BASE_W-1:0]   n1_base;
    logic [SCALE_W-1:0]  n1_scale;
    logic [QUAL_W:0]     w_lin_scale;
    logic [BASE_W+SCALE_W-1:0] w_prod_full;
    logic [PROD_W-1:0]   n2_prod;
    logic [WIDE_W-1:0]   n3_wide;
    logic [STEP_W-1:0]   w_step0, w_floor, n4_step;
    logic [NUM_W-1:0]    n5_num;
    logic [DEN_W-1:0]    n5_den;
    logic [MUL_W-1:0]    n5_mul;
    logic [MUL_W:0]      w_round;
    logic [RR_W-1:0]     w_rr;
    logic [OUT_W-1:0]    w_deq;
    logic [NUM_W-1:0]    w_in_rem;
    logic [DEN_W-1:0]    w_in_den;
    logic [QUO_W-1:0]    w_in_quo;
    logic [TRIAL_W-1:0]  w_trial;
    logic [NUM_W-1:0]    n_drem [NDIV];
    logic [QUO_W-1:0]    n_dquo [NDIV];
    logic [OUT_W-1:0]    w_q32, n_out_value;

    // Stage enables
    logic                w_en_out, w_en5, w_en4, w_en3, w_en2, w_en1;
    logic                w_en_div [NDIV];

    // Let a stage move when it is empty or the next one moves
    always_comb begin
        w_en_out = !r_out_valid || !i_stall;
        w_en_div[NDIV-1] = !r_dv[NDIV-1] || w_en_out;
        for (int k = NDIV - 2; k >= 0; k--) begin
            w_en_div[k] = !r_dv[k] || w_en_div[k+1];
        end
        w_en5 = !r5_valid || w_en_div[0];
        w_en4 = !r4_valid || w_en5;
        w_en3 = !r3_valid || w_en4;
        w_en2 = !r2_valid || w_en3;
        w_en1 = !r1_valid || w_en2;
    end

    assign o_stall     = !w_en1;
    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;

    // Clamp quality and look up base and scale
    always_comb begin
        w_q = r_quality;
        if (w_q < jbq_pkg::QUAL_MIN) begin
            w_q = jbq_pkg::QUAL_MIN;
        end
        if (w_q > jbq_pkg::QUAL_MAX) begin
            w_q = jbq_pkg::QUAL_MAX;
        end
        w_lin_scale = jbq_pkg::SCALE_TOP - {w_q, 1'b0};
        if (w_q < jbq_pkg::QUAL_KNEE) begin
            n1_scale = jbq_pkg::SCALE_TABLE[w_q[5:0]];
        end else begin
            n1_scale = {{(SCALE_W-QUAL_W-1){1'b0}}, w_lin_scale};
        end
        n1_base = jbq_pkg::BASE_TABLE[{i_coef_row, i_coef_col}];
        n1_quad = i_coef_row[POS_W-1] && i_coef_col[POS_W-1];
        n1_neg  = i_coef_value[jbq_pkg::COEF_W-1];
        n1_mag  = n1_neg ? (~$unsigned(i_coef_value) + 16'd1) : $unsigned(i_coef_value);
    end

    // Scale the base, then divide by 25 after the times-64 (256 / 100)
    always_comb begin
        w_prod_full = r1_base * r1_scale;
        n2_prod     = w_prod_full[PROD_W-1:0];
        n3_wide     = {r2_prod, {PRE_W{1'b0}}} * jbq_pkg::RECIP_25;
    end

    // Apply the floor of one and the quadrant factor of 1.5
    always_comb begin
        w_step0 = r3_wide[jbq_pkg::RECIP_SHIFT +: STEP_W];
        w_floor = (w_step0 < jbq_pkg::STEP_ONE) ? jbq_pkg::STEP_ONE : w_step0;
        n4_step = r3_quad ? (w_floor + (w_floor >> 1)) : w_floor;
    end

    // Form the rounding divide operands and the dequantize product
    always_comb begin
        n5_num = {2'b00, r4_mag, 5'b00000} + r4_step;
        n5_den = {r4_step, 1'b0};
        n5_mul = r4_mag * r4_step;
    end

    // Round and saturate the dequantized value
    always_comb begin
        w_round = {1'b0, r5_mul} + 40'd8;
        w_rr    = w_round[MUL_W:4];
        if (r5_neg) begin
            if (w_rr > 36'h080000000) begin
                w_deq = 32'h80000000;
            end else begin
                w_deq = 32'd0 - w_rr[OUT_W-1:0];
            end
        end else begin
            if (w_rr > 36'h07FFFFFFF) begin
                w_deq = 32'h7FFFFFFF;
            end else begin
                w_deq = w_rr[OUT_W-1:0];
            end
        end
    end

    // Restoring divide, one quotient bit per stage, most significant first
    always_comb begin
        w_in_rem = '0;
        w_in_den = '0;
        w_in_quo = '0;
        w_trial  = '0;
        for (int k = 0; k < NDIV; k++) begin
            if (k == 0) begin
                w_in_rem = r5_num;
                w_in_den = r5_den;
                w_in_quo = '0;
            end else begin
                w_in_rem = r_drem[k-1];
                w_in_den = r_dden[k-1];
                w_in_quo = r_dquo[k-1];
            end
            w_trial = {{QUO_W{1'b0}}, w_in_den} << (QUO_W - 1 - k);
            if ({{(TRIAL_W-NUM_W){1'b0}}, w_in_rem} >= w_trial) begin
                n_drem[k] = w_in_rem - w_trial[NUM_W-1:0];
                n_dquo[k] = w_in_quo | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
                n_drem[k] = w_in_rem;
                n_dquo[k] = w_in_quo;
            end
        end
    end

    // Pick the result and apply the sign for quantize
    always_comb begin
        w_q32 = {{(OUT_W-QUO_W){1'b0}}, r_dquo[NDIV-1]};
        if (r_ddir[NDIV-1] == jbq_pkg::DIR_DEQUANT) begin
            n_out_value = r_dres[NDIV-1];
        end else if (r_dneg[NDIV-1]) begin
            n_out_value = 32'd0 - w_q32;
        end else begin
            n_out_value = w_q32;
        end
    end

    // Hold configuration and advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality   <= jbq_pkg::QUAL_RESET;
            r_direction <= jbq_pkg::DIR_QUANT;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            for (int k = 0; k < NDIV; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    jbq_pkg::REG_QUALITY:   r_quality   <= i_cfg_data;
                    jbq_pkg::REG_DIRECTION: r_direction <= i_cfg_data[0];
                endcase
            end
            if (w_en1) r1_valid <= i_valid;
            if (w_en2) r2_valid <= r1_valid;
            if (w_en3) r3_valid <= r2_valid;
            if (w_en4) r4_valid <= r3_valid;
            if (w_en5) r5_valid <= r4_valid;
            if (w_en_div[0]) r_dv[0] <= r5_valid;
            for (int k = 1; k < NDIV; k++) begin
                if (w_en_div[k]) r_dv[k] <= r_dv[k-1];
            end
            if (w_en_out) r_out_valid <= r_dv[NDIV-1];
        end
    end

    // Advance payload with its stage
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_dir   <= r_direction;
            r1_neg   <= n1_neg;
            r1_quad  <= n1_quad;
            r1_mag   <= n1_mag;
            r1_base  <= n1_base;
            r1_scale <= n1_scale;
        end
        if (w_en2) begin
            r2_dir  <= r1_dir;
            r2_neg  <= r1_neg;
            r2_quad <= r1_quad;
            r2_mag  <= r1_mag;
            r2_prod <= n2_prod;
        end
        if (w_en3) begin
            r3_dir  <= r2_dir;
            r3_neg  <= r2_neg;
            r3_quad <= r2_quad;
            r3_mag  <= r2_mag;
            r3_wide <= n3_wide;
        end
        if (w_en4) begin
            r4_dir  <= r3_dir;
            r4_neg  <= r3_neg;
            r4_mag  <= r3_mag;
            r4_step <= n4_step;
        end
        if (w_en5) begin
            r5_dir <= r4_dir;
            r5_neg <= r4_neg;
            r5_num <= n5_num;
            r5_den <= n5_den;
            r5_mul <= n5_mul;
        end
        if (w_en_div[0]) begin
            r_ddir[0] <= r5_dir;
            r_dneg[0] <= r5_neg;
            r_drem[0] <= n_drem[0];
            r_dden[0] <= r5_den;
            r_dquo[0] <= n_dquo[0];
            r_dres[0] <= w_deq;
        end
        for (int k = 1; k < NDIV; k++) begin
            if (w_en_div[k]) begin
                r_ddir[k] <= r_ddir[k-1];
                r_dneg[k] <= r_dneg[k-1];
                r_drem[k] <= n_drem[k];
                r_dden[k] <= r_dden[k-1];
                r_dquo[k] <= n_dquo[k];
                r_dres[k] <= r_dres[k-1];
            end
        end
        if (w_en_out) begin
            r_out_value <= n_out_value;
        end
    end

endmodule

[rtl/jbq_checker.sv]
// Port-level checks for the JPEG block quantizer and their bind to the top level.
`timescale 1ns / 1ps

module jbq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [jbq_pkg::OUT_W-1:0]   o_out_value
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input backs up only behind a full, stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output can drain");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_value)))
        else $error("stalled result changed or dropped");

    // Drop a result only after it was taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> ($past(!i_stall) || $past(!i_rst_n)))
        else $error("result dropped without being taken");

endmodule

bind jpeg_block_quantizer jbq_checker u_jbq_checker (.*);
